// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)

`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== design/tnps_pkg.sv =====
// Types and constants for the three nearest point selector.
// No dependencies.
`default_nettype none

package tnps_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DIST_W  = SQ_W + 1;
    localparam int NUM_W   = 16;
    localparam int RANK_W  = 2;
    localparam int N_SLOTS = 3;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(N_SLOTS - 1);

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } pt_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
        pt_t               pt;
    } slot_t;

    typedef struct packed {
        logic done;
        logic shift;
    } chain_t;

endpackage

`default_nettype wire

// ===== design/tnps_dist.sv =====
// Squared distance pipeline: difference, square, sum (three stages).
// Depends on tnps_pkg.
`default_nettype none

module tnps_dist
    import tnps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire pt_t                in_pt,
    input  wire logic               in_final,
    input  wire logic [COORD_W-1:0] origin_x,
    input  wire logic [COORD_W-1:0] origin_y,
    input  wire logic [COORD_W-1:0] origin_z,
    output logic                    out_valid,
    output logic [DIST_W-1:0]       out_dist,
    output pt_t                     out_pt,
    output logic                    out_final
);

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dz_next;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0] sum_reg, sum_next;
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_final_reg, b_final_reg, c_final_reg;
    pt_t a_pt_reg, b_pt_reg, c_pt_reg;

    assign dx_next = $signed({in_pt.x[COORD_W-1], in_pt.x})
                   - $signed({origin_x[COORD_W-1], origin_x});
    assign dy_next = $signed({in_pt.y[COORD_W-1], in_pt.y})
                   - $signed({origin_y[COORD_W-1], origin_y});
    assign dz_next = $signed({in_pt.z[COORD_W-1], in_pt.z})
                   - $signed({origin_z[COORD_W-1], origin_z});

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;

    assign sum_next = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            dz_reg      <= dz_next;
            a_pt_reg    <= in_pt;
            a_final_reg <= in_final;
            sqx_reg     <= prod_x[SQ_W-1:0];
            sqy_reg     <= prod_y[SQ_W-1:0];
            sqz_reg     <= prod_z[SQ_W-1:0];
            b_pt_reg    <= a_pt_reg;
            b_final_reg <= a_final_reg;
            sum_reg     <= sum_next;
            c_pt_reg    <= b_pt_reg;
            c_final_reg <= b_final_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_dist  = sum_reg;
    assign out_pt    = c_pt_reg;
    assign out_final = c_final_reg;

endmodule

`default_nettype wire

// ===== design/tnps_cell.sv =====
// One ranked slot of the sorted nearest list; cells chain by rank.
// Depends on tnps_pkg.
`default_nettype none

module tnps_cell
    import tnps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              upd,
    input  wire logic              clear,
    input  wire logic [DIST_W-1:0] new_dist,
    input  wire pt_t               new_pt,
    input  wire slot_t             prev_slot,
    input  wire chain_t            chain_in,
    output chain_t                 chain_out,
    output slot_t                  slot,
    output slot_t                  slot_next
);

    slot_t slot_reg;
    logic  hit_eq, hit_lt;

    assign hit_eq = slot_reg.valid && (slot_reg.dsq == new_dist);
    assign hit_lt = !slot_reg.valid || (new_dist < slot_reg.dsq);

    always_comb begin
        slot_next = slot_reg;
        if (chain_in.shift) begin
            slot_next = prev_slot;
        end else if (!chain_in.done && (hit_eq || hit_lt)) begin
            slot_next.valid = 1'b1;
            slot_next.dsq   = new_dist;
            slot_next.pt    = new_pt;
        end
    end

    assign chain_out.done  = chain_in.done | hit_eq | hit_lt;
    assign chain_out.shift = chain_in.shift | (!chain_in.done && hit_lt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (upd) begin
            slot_reg.valid <= slot_next.valid && !clear;
            slot_reg.dsq   <= slot_next.dsq;
            slot_reg.pt    <= slot_next.pt;
        end
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

// ===== design/three_nearest_point_select.sv =====
// Top level of the three nearest point selector.
// Depends on tnps_pkg, tnps_dist, tnps_cell and assert_macros.svh.
//
// Takes one point per cycle while s_tready is high. Each point reaches the row
// of three ranked cells through the difference, square and sum registers, and
// the cells rank it combinationally and register the updated slots. On the point
// marked tlast the three updated slots are copied to a result buffer and the
// cells clear; the buffer sends three beats, rank 0 to 2, the last with tlast.
// A marked point that reaches the cells while the buffer still holds the
// previous set's beats stalls the input until the buffer has drained.
`default_nettype none

`include "assert_macros.svh"

module three_nearest_point_select
    import tnps_pkg::*;
#(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // point_x, point_y, point_z
    input  wire logic        s_tlast,   // final_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // rank, point_number, near_x, near_y, near_z, pad
    output logic             m_tuser,   // found
    output logic             m_tlast    // last_of_run
);

    localparam int CNT_W = $clog2(MAX_POINTS);
    localparam int NUMB  = (CNT_W < NUM_W) ? CNT_W : NUM_W;

    logic [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               s_acc, adv, upd;
    pt_t                in_pt;

    logic               c_valid, c_final;
    logic [DIST_W-1:0]  c_dist;
    pt_t                c_pt;

    slot_t  slot_q [N_SLOTS];
    slot_t  slot_nx [N_SLOTS];
    slot_t  prev_q [N_SLOTS];
    chain_t chain [N_SLOTS+1];

    slot_t             bank_reg [N_SLOTS];
    logic              busy_reg;
    logic [RANK_W-1:0] rank_reg;
    slot_t             cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_ORIGIN_Z: origin_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv      = !(c_valid && c_final && busy_reg);
    assign s_tready = adv;
    assign s_acc    = s_tvalid && adv;
    assign upd      = adv && c_valid;

    always_comb begin
        if (s_tlast || cnt_reg == CNT_W'(MAX_POINTS - 1)) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_acc) begin
            cnt_reg <= cnt_next;
        end
    end

    assign in_pt.num = NUM_W'(cnt_reg[NUMB-1:0]);
    assign in_pt.x   = s_tdata[23:0];
    assign in_pt.y   = s_tdata[47:24];
    assign in_pt.z   = s_tdata[71:48];

    tnps_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_acc),
        .in_pt     (in_pt),
        .in_final  (s_tlast),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .out_valid (c_valid),
        .out_dist  (c_dist),
        .out_pt    (c_pt),
        .out_final (c_final)
    );

    assign chain[0]  = '0;
    assign prev_q[0] = '0;

    for (genvar k = 0; k < N_SLOTS; k++) begin : g_cell
        if (k > 0) begin : g_prev
            assign prev_q[k] = slot_q[k-1];
        end
        tnps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .upd       (upd),
            .clear     (c_final),
            .new_dist  (c_dist),
            .new_pt    (c_pt),
            .prev_slot (prev_q[k]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .slot      (slot_q[k]),
            .slot_next (slot_nx[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rank_reg <= '0;
        end else if (upd && c_final) begin
            busy_reg <= 1'b1;
            rank_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            if (rank_reg == RANK_LAST) begin
                busy_reg <= 1'b0;
                rank_reg <= '0;
            end else begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd && c_final) begin
            for (int i = 0; i < N_SLOTS; i++) begin
                bank_reg[i] <= slot_nx[i];
            end
        end
    end

    assign cur      = bank_reg[rank_reg];
    assign m_tvalid = busy_reg;
    assign m_tuser  = cur.valid;
    assign m_tlast  = (rank_reg == RANK_LAST);
    assign m_tdata  = {6'b0,
                       cur.valid ? cur.pt.z   : {COORD_W{1'b0}},
                       cur.valid ? cur.pt.y   : {COORD_W{1'b0}},
                       cur.valid ? cur.pt.x   : {COORD_W{1'b0}},
                       cur.valid ? cur.pt.num : {NUM_W{1'b0}},
                       rank_reg};

    `ASSERT_IMPLY(a_sorted_01, aclk, aresetn, slot_q[1].valid, slot_q[0].valid && (slot_q[0].dsq < slot_q[1].dsq), "cells 0 and 1 out of order")
    `ASSERT_IMPLY(a_sorted_12, aclk, aresetn, slot_q[2].valid, slot_q[1].valid && (slot_q[1].dsq < slot_q[2].dsq), "cells 1 and 2 out of order")
    `ASSERT_NEXT(a_drain, aclk, aresetn, m_tvalid && m_tready && m_tlast && !(upd && c_final), !m_tvalid, "result buffer not empty after last beat")
    `ASSERT_NEXT(a_clear, aclk, aresetn, upd && c_final, !slot_q[0].valid && !slot_q[1].valid && !slot_q[2].valid, "cells not cleared after set end")

endmodule

`default_nettype wire

// ===== tb/three_nearest_point_select_test.sv =====
// Self-checking testbench for three_nearest_point_select: streams point sets,
// predicts the three ranked nearest results per set and checks every beat.
// Depends on tnps_pkg and the three_nearest_point_select RTL.

module three_nearest_point_select_test;
    import tnps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              found;
        pt_t               pt;
        logic              last;
    } near_beat_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               fin;
        logic               solo;
    } dir_row_t;

    // solo rows are one-point sets whose results are written out directly
    localparam dir_row_t DIRECTED [20] = '{
        '{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1},
        '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1},
        '{24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1},
        '{24'h000100, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000000, 24'h000100, 24'h000000, 1'b0, 1'b0},
        '{24'h000000, 24'h000000, 24'hFFFE00, 1'b0, 1'b0},
        '{24'hFFFD00, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000000, 24'h000000, 24'h000100, 1'b1, 1'b0},
        '{24'h000005, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000000, 24'hFFFFFB, 24'h000000, 1'b1, 1'b0},
        '{24'h000002, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000001, 24'h000000, 24'h000000, 1'b1, 1'b0},
        '{24'h00000A, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h00001E, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000014, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000005, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000028, 24'h000000, 24'h000000, 1'b0, 1'b0},
        '{24'h000019, 24'h000000, 24'h000000, 1'b1, 1'b0},
        '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0},
        '{24'h800000, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_ORIGIN_X;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // point_x, point_y, point_z
    logic        s_tlast = 1'b0; // final_point
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // rank, point_number, near_x, near_y, near_z, pad
    logic        m_tuser;        // found
    logic        m_tlast;        // last_of_run

    three_nearest_point_select i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // predictor state
    slot_t            ranked [N_SLOTS];
    logic [NUM_W-1:0] arrivals = '0;
    logic [23:0]      org_x = '0;
    logic [23:0]      org_y = '0;
    logic [23:0]      org_z = '0;
    near_beat_t       nearest_q [$];

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   error_cnt = 0;
    int   points_sent = 0;
    int   sets_sent = 0;
    int   beats_checked = 0;
    int   cycle_cnt = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    initial begin
        for (int k = 0; k < N_SLOTS; k++) ranked[k] = '0;
    end

    function automatic void tally_point(input logic [23:0] x, y, z, input logic fin,
                                        input bit emit);
        longint            dx, dy, dz;
        logic [DIST_W-1:0] d;
        slot_t             cand;
        bit                placed;
        near_beat_t        beat;
        dx = longint'($signed(x)) - longint'($signed(org_x));
        dy = longint'($signed(y)) - longint'($signed(org_y));
        dz = longint'($signed(z)) - longint'($signed(org_z));
        d = DIST_W'(dx * dx + dy * dy + dz * dz);
        cand.valid = 1'b1;
        cand.dsq = d;
        cand.pt = '{num: arrivals, x: x, y: y, z: z};
        placed = 0;
        for (int k = 0; k < N_SLOTS && !placed; k++) begin
            if (ranked[k].valid && ranked[k].dsq == d) begin
                ranked[k] = cand;
                placed = 1;
            end else if (!ranked[k].valid || d < ranked[k].dsq) begin
                for (int j = N_SLOTS - 1; j > k; j--) ranked[j] = ranked[j-1];
                ranked[k] = cand;
                placed = 1;
            end
        end
        arrivals = arrivals + 1'b1;
        if (fin) begin
            for (int k = 0; k < N_SLOTS; k++) begin
                beat.rank = RANK_W'(k);
                beat.found = ranked[k].valid;
                beat.pt = ranked[k].valid ? ranked[k].pt : '0;
                beat.last = (beat.rank == RANK_LAST);
                if (emit) nearest_q.push_back(beat);
                ranked[k] = '0;
            end
            arrivals = '0;
        end
    endfunction

    function automatic logic [23:0] pick_coord(input logic [23:0] o);
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3, 4: return o + 24'($urandom_range(0, 6)) - 24'd3;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got, want);
        if (error_cnt < 40)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_cnt++;
    endtask

    task automatic set_origin(input logic [23:0] ox, oy, oz);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ORIGIN_X;
        cfg_wdata <= ox;
        @(posedge aclk);
        cfg_index <= REG_ORIGIN_Y;
        cfg_wdata <= oy;
        @(posedge aclk);
        cfg_index <= REG_ORIGIN_Z;
        cfg_wdata <= oz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        org_x = ox;
        org_y = oy;
        org_z = oz;
    endtask

    task automatic send_point(input logic [23:0] x, y, z, input logic fin, input logic solo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tlast <= fin;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        points_sent++;
        if (fin) sets_sent++;
        tally_point(x, y, z, fin, !solo);
        if (solo) begin
            nearest_q.push_back('{rank: '0, found: 1'b1,
                                  pt: '{num: '0, x: x, y: y, z: z}, last: 1'b0});
            nearest_q.push_back('{rank: RANK_W'(1), found: 1'b0, pt: '0, last: 1'b0});
            nearest_q.push_back('{rank: RANK_LAST, found: 1'b0, pt: '0, last: 1'b1});
        end
    endtask

    task automatic run_sets(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_point(pick_coord(org_x), pick_coord(org_y), pick_coord(org_z),
                           i == len - 1, 1'b0);
            sent += len;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (nearest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result side: random stall, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        near_beat_t got;
        near_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rank = m_tdata[1:0];
            got.found = m_tuser;
            got.pt.num = m_tdata[17:2];
            got.pt.x = m_tdata[41:18];
            got.pt.y = m_tdata[65:42];
            got.pt.z = m_tdata[89:66];
            got.last = m_tlast;
            if (nearest_q.size() == 0) begin
                note_mismatch("unexpected result beat", got.rank, '0);
            end else begin
                want = nearest_q.pop_front();
                beats_checked++;
                if (got.rank !== want.rank) note_mismatch("rank", got.rank, want.rank);
                if (got.found !== want.found) note_mismatch("found", got.found, want.found);
                if (got.pt.num !== want.pt.num)
                    note_mismatch("point_number", got.pt.num, want.pt.num);
                if (got.pt.x !== want.pt.x) note_mismatch("near_x", got.pt.x, want.pt.x);
                if (got.pt.y !== want.pt.y) note_mismatch("near_y", got.pt.y, want.pt.y);
                if (got.pt.z !== want.pt.z) note_mismatch("near_z", got.pt.z, want.pt.z);
                if (got.last !== want.last) note_mismatch("last_of_run", got.last, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, nearest_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset origin, then origin at mixed extremes
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) set_origin(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
            foreach (DIRECTED[r])
                send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
                           DIRECTED[r].fin, DIRECTED[r].solo);
            s_tvalid <= 1'b0;
            wait_idle();
        end

        // random sets under each idle and stall mode
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: set_origin(24'($urandom), 24'($urandom), 24'($urandom));
                1: set_origin(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
                2: set_origin(24'h800000, 24'h800000, 24'h800000);
                default: set_origin(24'($urandom_range(0, 15)), 24'($urandom), 24'h000000);
            endcase
            send_idle_pct = (mode == 1) ? 68 : (mode == 3) ? 24 : 0;
            stall_pct = (mode == 2) ? 68 : (mode == 3) ? 24 : 0;
            run_sets(20);
            wait_idle();
        end

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct = 0;
        set_origin(24'($urandom), 24'($urandom), 24'($urandom));
        hold_req <= ~hold_req;
        run_sets(24);
        wait_idle();

        $display("%0d points in %0d sets, %0d result beats checked, %0d mismatches",
                 points_sent, sets_sent, beats_checked, error_cnt);
        $display("origins at reset, extremes and random; idle, stall and long hold-off phases");
        if (error_cnt == 0 && nearest_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/tnps_pkg.sv
design/tnps_dist.sv
design/tnps_cell.sv
design/three_nearest_point_select.sv
tb/three_nearest_point_select_test.sv
